// ===== hw/rtl/xsr_pkg.sv =====
// Shared constants, types and helper functions of the xoshiro256** ranged generator.
package xsr_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = WORD_W / 2;
    localparam int GEN_WORDS = 4;
    localparam int WIDX_W    = $clog2(GEN_WORDS);
    localparam int DIV_CNT_W = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] SM_MUL1  = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94d0_49bb_1331_11eb;

    localparam int SM_SH1    = 30;
    localparam int SM_SH2    = 27;
    localparam int SM_SH3    = 31;
    localparam int ROT_OUT   = 7;
    localparam int ROT_S3    = 45;
    localparam int SHIFT_S1  = 17;

    typedef enum logic
    {
        OP_RAW    = 1'b0,
        OP_RANGED = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        RES_X    = 2'd0,
        RES_REM  = 2'd1,
        RES_ZERO = 2'd2
    } res_src_t;

    typedef struct packed
    {
        logic     seed_start;
        logic     sm_add;
        logic     mul2_start;
        logic     word_wr;
        logic     item_load;
        logic     draw;
        logic     div_x_start;
        logic     div_lim_start;
        logic     lim_load;
        logic     res_load;
        res_src_t res_src;
        logic     out_load;
    } xsr_cmd_t;

    typedef struct packed
    {
        logic mul_done;
        logic div_done;
        logic word_last;
        logic op_ranged;
        logic bound_zero;
        logic x_lt_bound;
        logic lim_known;
        logic x_lt_lim;
        logic out_free;
    } xsr_sts_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v, input int k);
        return (v << k) | (v >> (WORD_W - k));
    endfunction

endpackage

// ===== hw/rtl/xsr_mul.sv =====
// Iterative 64 x 64 multiplier keeping the low 64 bits, one 32 x 32 partial product a cycle.
module xsr_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [xsr_pkg::WORD_W-1:0] a,
    input  logic [xsr_pkg::WORD_W-1:0] b,
    output logic                       done,
    output logic [xsr_pkg::WORD_W-1:0] prod
);
    import xsr_pkg::*;

    localparam logic [1:0] STEP_LL  = 2'd0;
    localparam logic [1:0] STEP_LH  = 2'd1;
    localparam logic [1:0] STEP_HL  = 2'd2;
    localparam logic [1:0] STEP_ACC = 2'd3;

    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] pp_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [1:0]        step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [HALF_W-1:0] mx;
    logic [HALF_W-1:0] my;
    logic [WORD_W-1:0] pp;

    // The high-by-high product falls wholly above bit 63 and is never formed.
    always_comb
    begin
        mx = (step_reg == STEP_HL) ? a_reg[WORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
        my = (step_reg == STEP_LH) ? b_reg[WORD_W-1:HALF_W] : b_reg[HALF_W-1:0];
        pp = WORD_W'(mx) * WORD_W'(my);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_LL;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_LL;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == STEP_ACC)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            pp_reg <= pp;
            case (step_reg)
                STEP_LH:  acc_reg <= pp_reg;
                STEP_HL,
                STEP_ACC: acc_reg <= acc_reg + {pp_reg[HALF_W-1:0], {HALF_W{1'b0}}};
                default:  acc_reg <= acc_reg;
            endcase
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== hw/rtl/xsr_div.sv =====
// Restoring radix-2 divider giving the 64-bit remainder, one quotient bit a cycle.
module xsr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [xsr_pkg::WORD_W-1:0] dividend,
    input  logic [xsr_pkg::WORD_W-1:0] divisor,
    output logic                       done,
    output logic [xsr_pkg::WORD_W-1:0] rem
);
    import xsr_pkg::*;

    logic [WORD_W-1:0]    rem_reg;
    logic [WORD_W-1:0]    dvd_reg;
    logic [WORD_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [WORD_W:0]      shifted;
    logic [WORD_W:0]      diff;
    logic                 fits;
    logic [WORD_W-1:0]    rem_next;

    // The partial remainder stays below the divisor, so the shifted value needs one extra bit.
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[WORD_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == {DIV_CNT_W{1'b1}})
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== hw/rtl/xsr_dp.sv =====
// Datapath: seed and state words, SplitMix64 expansion, generator step, limit and output registers.
module xsr_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [xsr_pkg::WORD_W-1:0] cfg_wr_data,
    input  logic                       opcode,
    input  logic [xsr_pkg::WORD_W-1:0] range_bound,
    input  xsr_pkg::xsr_cmd_t          cmd,
    output xsr_pkg::xsr_sts_t          sts,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [xsr_pkg::WORD_W-1:0] out_data
);
    import xsr_pkg::*;

    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] ctr_reg;
    logic [WIDX_W-1:0] widx_reg;
    logic [WORD_W-1:0] gen_words_reg [GEN_WORDS];
    logic              opcode_reg;
    logic [WORD_W-1:0] bound_reg;
    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] lim_reg;
    logic              lim_ok_reg;
    logic [WORD_W-1:0] res_reg;
    logic [WORD_W-1:0] out_data_reg;
    logic              out_valid_reg;

    logic [WORD_W-1:0] ctr_sum;
    logic [WORD_W-1:0] mix30;
    logic [WORD_W-1:0] mix27;
    logic [WORD_W-1:0] word_fin;
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] mul_b;
    logic              mul_start;
    logic              mul_done;
    logic [WORD_W-1:0] mul_prod;
    logic [WORD_W-1:0] w1_x5;
    logic [WORD_W-1:0] w1_rot;
    logic [WORD_W-1:0] draw_out;
    logic [WORD_W-1:0] neg_bound;
    logic              big_bound;
    logic [WORD_W-1:0] lim_val;
    logic              div_start;
    logic [WORD_W-1:0] div_dividend;
    logic              div_done;
    logic [WORD_W-1:0] div_rem;

    always_comb
    begin
        ctr_sum  = ctr_reg + SM_GAMMA;
        mix30    = ctr_sum ^ (ctr_sum >> SM_SH1);
        mix27    = mul_prod ^ (mul_prod >> SM_SH2);
        word_fin = mul_prod ^ (mul_prod >> SM_SH3);

        mul_start = cmd.sm_add | cmd.mul2_start;
        mul_a     = cmd.sm_add ? mix30 : mix27;
        mul_b     = cmd.sm_add ? SM_MUL1 : SM_MUL2;

        // Multiplications by 5 and 9 are shift-and-add.
        w1_x5    = gen_words_reg[1] + (gen_words_reg[1] << 2);
        w1_rot   = rotl64(w1_x5, ROT_OUT);
        draw_out = w1_rot + (w1_rot << 3);

        // For a bound above 2^63 the quotient of 2^64 is one, so the limit is simply 2^64 - n.
        neg_bound = '0 - bound_reg;
        big_bound = bound_reg[WORD_W-1] && (bound_reg[WORD_W-2:0] != '0);
        lim_val   = big_bound ? neg_bound : lim_reg;

        div_start    = cmd.div_x_start | cmd.div_lim_start;
        div_dividend = cmd.div_lim_start ? neg_bound : x_reg;
    end

    xsr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    xsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (bound_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            widx_reg      <= '0;
            lim_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                seed_reg <= cfg_wr_data;
            end
            if (cmd.seed_start)
            begin
                widx_reg <= '0;
            end
            else if (cmd.word_wr)
            begin
                widx_reg <= widx_reg + 1'b1;
            end
            if (cmd.item_load)
            begin
                lim_ok_reg <= 1'b0;
            end
            else if (cmd.lim_load)
            begin
                lim_ok_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seed_start)
        begin
            ctr_reg <= seed_reg;
        end
        else if (cmd.sm_add)
        begin
            ctr_reg <= ctr_sum;
        end

        if (cmd.word_wr)
        begin
            gen_words_reg[widx_reg] <= word_fin;
        end
        else if (cmd.draw)
        begin
            gen_words_reg[0] <= gen_words_reg[0] ^ gen_words_reg[3] ^ gen_words_reg[1];
            gen_words_reg[1] <= gen_words_reg[1] ^ gen_words_reg[2] ^ gen_words_reg[0];
            gen_words_reg[2] <= gen_words_reg[2] ^ gen_words_reg[0]
                                ^ (gen_words_reg[1] << SHIFT_S1);
            gen_words_reg[3] <= rotl64(gen_words_reg[3] ^ gen_words_reg[1], ROT_S3);
        end

        if (cmd.item_load)
        begin
            opcode_reg <= opcode;
            bound_reg  <= range_bound;
        end
        if (cmd.draw)
        begin
            x_reg <= draw_out;
        end
        if (cmd.lim_load)
        begin
            lim_reg <= div_rem;
        end
        if (cmd.res_load)
        begin
            case (cmd.res_src)
                RES_X:    res_reg <= x_reg;
                RES_REM:  res_reg <= div_rem;
                RES_ZERO: res_reg <= '0;
                default:  res_reg <= '0;
            endcase
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    always_comb
    begin
        sts.mul_done   = mul_done;
        sts.div_done   = div_done;
        sts.word_last  = widx_reg == WIDX_W'(GEN_WORDS - 1);
        sts.op_ranged  = opcode_reg == OP_RANGED;
        sts.bound_zero = bound_reg == '0;
        sts.x_lt_bound = x_reg < bound_reg;
        sts.lim_known  = big_bound | lim_ok_reg;
        sts.x_lt_lim   = x_reg < lim_val;
        sts.out_free   = !out_valid_reg | out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A new result must never overwrite one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before it was taken");

    // The divider is never started on a zero bound.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (bound_reg != '0))
        else $error("division started with a zero divisor");

    // The computed rejection limit is a true remainder of the bound.
    a_lim_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lim_load |-> (div_rem < bound_reg))
        else $error("rejection limit not below the bound");

    // The generator state is never all zero when it is stepped.
    a_state_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.draw |-> ((gen_words_reg[0] | gen_words_reg[1] | gen_words_reg[2]
                       | gen_words_reg[3]) != '0))
        else $error("generator stepped from an all-zero state");

endmodule

// ===== hw/rtl/xsr_ctrl.sv =====
// Controller state machine sequencing seed expansion, draws, rejection and output.
module xsr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              in_valid,
    output logic              in_ready,
    output xsr_pkg::xsr_cmd_t cmd,
    input  xsr_pkg::xsr_sts_t sts
);
    import xsr_pkg::*;

    typedef enum logic [9:0]
    {
        S_SEED_START = 10'b00_0000_0001,
        S_SEED_ADD   = 10'b00_0000_0010,
        S_SEED_M1    = 10'b00_0000_0100,
        S_SEED_M2    = 10'b00_0000_1000,
        S_IDLE       = 10'b00_0001_0000,
        S_DRAW       = 10'b00_0010_0000,
        S_CHECK      = 10'b00_0100_0000,
        S_LIM        = 10'b00_1000_0000,
        S_DIV        = 10'b01_0000_0000,
        S_OUT        = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // A seed write takes priority, so an item never slips in ahead of the re-expansion.
    assign in_ready = (state_reg == S_IDLE) && !cfg_wr_en;

    always_comb
    begin
        cmd        = '0;
        cmd.res_src = RES_X;
        state_next = state_reg;
        unique case (state_reg)
            S_SEED_START:
            begin
                cmd.seed_start = 1'b1;
                state_next     = S_SEED_ADD;
            end
            S_SEED_ADD:
            begin
                cmd.sm_add = 1'b1;
                state_next = S_SEED_M1;
            end
            S_SEED_M1:
            begin
                if (sts.mul_done)
                begin
                    cmd.mul2_start = 1'b1;
                    state_next     = S_SEED_M2;
                end
            end
            S_SEED_M2:
            begin
                if (sts.mul_done)
                begin
                    cmd.word_wr = 1'b1;
                    state_next  = sts.word_last ? S_IDLE : S_SEED_ADD;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = S_DRAW;
                end
            end
            S_DRAW:
            begin
                if (sts.op_ranged && sts.bound_zero)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_src  = RES_ZERO;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.draw   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!sts.op_ranged)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_OUT;
                end
                else if (!sts.x_lt_bound)
                begin
                    // A draw at or above the bound is also above the limit and is kept.
                    cmd.div_x_start = 1'b1;
                    state_next      = S_DIV;
                end
                else if (sts.lim_known)
                begin
                    if (sts.x_lt_lim)
                    begin
                        state_next = S_DRAW;
                    end
                    else
                    begin
                        cmd.res_load = 1'b1;
                        state_next   = S_OUT;
                    end
                end
                else
                begin
                    cmd.div_lim_start = 1'b1;
                    state_next        = S_LIM;
                end
            end
            S_LIM:
            begin
                if (sts.div_done)
                begin
                    cmd.lim_load = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_src  = RES_REM;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_SEED_START;
            end
        endcase

        if (cfg_wr_en)
        begin
            state_next = S_SEED_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SEED_START;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/xoshiro256ss_ranged_prng.sv =====
// Top level of the xoshiro256** generator with SplitMix64 seeding and unbiased ranged output.
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser: opcode; tdata: range_bound
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: random_value
//  cfg       in         cfg_wr_en                      cfg_wr_data: seed_value
//
// A raw item loads its result in the check state that follows its draw; a ranged item whose draw
// needs the 64-step remainder divider is held in the divide state until the divider is done.
// Each rejected draw repeats the draw and check states; for a bound up to 2^63 the
// rejection limit is found once per item by a second division, started when a draw
// first falls below the bound. After reset and each seed write the state is re-expanded
// with s_axis_tready low. A result waits in the output register while the next item is
// taken; a stall only occurs when a new result finds that register still full.
module xoshiro256ss_ranged_prng (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [xsr_pkg::WORD_W-1:0] s_axis_tdata,   // [63:0] range_bound
    input  logic [0:0]                 s_axis_tuser,   // [0] opcode
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [xsr_pkg::WORD_W-1:0] m_axis_tdata,   // [63:0] random_value
    input  logic                       cfg_wr_en,
    input  logic [xsr_pkg::WORD_W-1:0] cfg_wr_data
);
    import xsr_pkg::*;

    xsr_cmd_t cmd;
    xsr_sts_t sts;

    xsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    xsr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .opcode      (s_axis_tuser[0]),
        .range_bound (s_axis_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_data    (m_axis_tdata)
    );

endmodule
